FILE: hw/rtl/blcd_pkg.sv
// Shared constants, types and elaboration-time tables for the breathing LED colour driver.
`timescale 1ns / 1ps

package blcd_pkg;

    // Timing of the glow
    localparam int unsigned PERIOD_MS       = 3200;
    localparam int unsigned MIN_INTERVAL_MS = 45;
    localparam int unsigned SINE_ENTRIES    = 256;

    // Field widths
    localparam int NOW_W     = 32;
    localparam int COLOR_W   = 16;
    localparam int CH_W      = 8;
    localparam int LEVEL_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Phase arithmetic widths
    localparam int REM_W  = $clog2(PERIOD_MS);
    localparam int REM0_W = $clog2(2 * PERIOD_MS);
    localparam int K_W    = $clog2(SINE_ENTRIES);
    localparam int Y_W    = $clog2(longint'(PERIOD_MS) * SINE_ENTRIES);

    // Reciprocal of the period for the quotient estimate (may be one low)
    localparam logic [NOW_W-1:0] DIV_MUL = NOW_W'((64'd1 << NOW_W) / PERIOD_MS);

    // Exact reciprocal for rem * SINE_ENTRIES / PERIOD_MS
    localparam int K_SHIFT = $clog2(longint'(SINE_ENTRIES) * PERIOD_MS * PERIOD_MS);
    localparam longint unsigned K_MUL = ((64'd1 << K_SHIFT) / PERIOD_MS) + 64'd1;
    localparam int KM_W = $clog2(K_MUL + 64'd1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_COLOR = 1'b0,
        CFG_ENABLED    = 1'b1
    } t_cfg_reg;

    // Request passed from the interval gate to the phase stages
    typedef struct packed {
        logic [NOW_W-1:0] now;
        logic             saving;
    } t_time_req;

    // Request passed from the phase stages to the scaling stages
    typedef struct packed {
        logic [K_W-1:0] k;
        logic           saving;
    } t_level_req;

    typedef logic [LEVEL_W-1:0] t_level_lut [SINE_ENTRIES];
    typedef logic [CH_W-1:0]    t_exp5_lut  [32];
    typedef logic [CH_W-1:0]    t_exp6_lut  [64];

    // Taylor series constants in Q30
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TRIG_DIV_SIN [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint unsigned TRIG_DIV_COS [7] = '{2, 12, 30, 56, 90, 132, 182};

    // Denominator of the level scaling, 100 in Q30
    localparam longint LEVEL_DEN = 100 * longint'(Q30_ONE);

    // Sine or cosine of a Q30 angle in the first quadrant, clamped to [0, 1]
    function automatic longint trig_q30(longint unsigned x, bit cosine);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = cosine ? Q30_ONE : x;
        sum  = longint'(term);
        for (int i = 0; i < 7; i++) begin
            if (cosine) begin
                term = ((term * x2) >> 30) / TRIG_DIV_COS[i];
            end else begin
                term = ((term * x2) >> 30) / TRIG_DIV_SIN[i];
            end
            if ((i % 2) == 1) begin
                sum = sum + longint'(term);
            end else begin
                sum = sum - longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
        end
        return sum;
    endfunction

    // Brightness level for one table entry, unsigned Q0.16
    function automatic logic [LEVEL_W-1:0] level_entry(longint unsigned k);
        longint unsigned four_k;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint          s;
        longint          num;
        longint          lvl;
        four_k = 4 * k;
        q      = four_k / SINE_ENTRIES;
        r      = four_k % SINE_ENTRIES;
        x      = (HALF_PI_Q30 * r) / SINE_ENTRIES;
        case (q[1:0])
            2'd0:    s =  trig_q30(x, 1'b0);
            2'd1:    s =  trig_q30(x, 1'b1);
            2'd2:    s = -trig_q30(x, 1'b0);
            default: s = -trig_q30(x, 1'b1);
        endcase
        num = 64 * longint'(Q30_ONE) + 36 * s;
        lvl = (num * 65536) / LEVEL_DEN;
        if (lvl > 65535) begin
            lvl = 65535;
        end
        return LEVEL_W'(lvl);
    endfunction

    function automatic t_level_lut build_level_lut();
        t_level_lut lut;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            lut[k] = level_entry(longint'(k));
        end
        return lut;
    endfunction

    // Expand a 5-bit channel to 8 bits
    function automatic t_exp5_lut build_exp5_lut();
        t_exp5_lut lut;
        for (int i = 0; i < 32; i++) begin
            lut[i] = CH_W'((i * 255) / 31);
        end
        return lut;
    endfunction

    // Expand a 6-bit channel to 8 bits
    function automatic t_exp6_lut build_exp6_lut();
        t_exp6_lut lut;
        for (int i = 0; i < 64; i++) begin
            lut[i] = CH_W'((i * 255) / 63);
        end
        return lut;
    endfunction

    localparam t_level_lut SINE_LUT = build_level_lut();
    localparam t_exp5_lut  EXP5_LUT = build_exp5_lut();
    localparam t_exp6_lut  EXP6_LUT = build_exp6_lut();

endpackage

FILE: hw/rtl/blcd_in_if.sv
// Input channel carrying time samples with their power-saving and force flags.
`timescale 1ns / 1ps

interface blcd_in_if;
    import blcd_pkg::*;

    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;
    logic             saving;
    logic             force_update;

    modport source (output valid, output now_ms, output saving, output force_update,
                    input ready);
    modport sink   (input valid, input now_ms, input saving, input force_update,
                    output ready);
endinterface

FILE: hw/rtl/blcd_out_if.sv
// Output channel carrying the scaled RGB intensities for the LED.
`timescale 1ns / 1ps

interface blcd_out_if;
    import blcd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hw/rtl/blcd_gate.sv
// Update interval check, last-update register and input stage.
`timescale 1ns / 1ps

module blcd_gate
    import blcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_enabled,
    blcd_in_if.sink    i_in,
    output logic       o_valid,
    output t_time_req  o_req,
    input  logic       i_ready
);

    logic [NOW_W-1:0] r_last;
    logic [NOW_W-1:0] n_last;
    logic             r_valid;
    t_time_req        r_req;
    logic             w_accept;
    logic             w_update;
    logic [NOW_W-1:0] w_eff_last;
    logic [NOW_W-1:0] w_elapsed;

    // Take a request when the stage is empty or drains this cycle
    assign i_in.ready = !r_valid || i_ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Clear the last update time on force, then check the interval
    assign w_eff_last = i_in.force_update ? '0 : r_last;
    assign w_elapsed  = i_in.now_ms - w_eff_last;
    assign w_update   = i_enabled && (w_elapsed >= NOW_W'(MIN_INTERVAL_MS));

    always_comb begin
        n_last = r_last;
        if (w_accept) begin
            n_last = w_update ? i_in.now_ms : w_eff_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_last <= n_last;
            if (i_in.ready) begin
                r_valid <= w_accept && w_update;
            end
        end
    end

    // Hold the payload of updates only
    always_ff @(posedge i_clk) begin
        if (w_accept && w_update) begin
            r_req.now    <= i_in.now_ms;
            r_req.saving <= i_in.saving;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

`ifndef SYNTHESIS
    a_force_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.force_update && !w_update) |=> (r_last == '0))
        else $error("last update time not cleared by force");
    a_valid_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !$rose(r_valid))
        else $error("update raised without an accepted request");
    a_update_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_update) |=> (r_last == r_req.now))
        else $error("update time not recorded");
`endif

endmodule

FILE: hw/rtl/blcd_phase.sv
// Phase stages: time modulo the period, then the sine table index.
`timescale 1ns / 1ps

module blcd_phase
    import blcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_time_req  i_req,
    output logic       o_ready,
    output logic       o_valid,
    output t_level_req o_req,
    input  logic       i_ready
);

    localparam int KP_W = Y_W + KM_W;

    logic                      r_v2;
    logic                      r_v3;
    logic                      r_v4;
    logic                      w_rdy2;
    logic                      w_rdy3;
    logic                      w_rdy4;
    logic [NOW_W-1:0]          r_s2_now;
    logic [2*NOW_W-1:0]        r_s2_prod;
    logic                      r_s2_saving;
    logic [REM0_W-1:0]         r_s3_rem0;
    logic                      r_s3_saving;
    t_level_req                r_s4_req;
    logic [NOW_W-1:0]          w_quot;
    logic [NOW_W-1:0]          w_diff;
    logic [REM_W-1:0]          w_rem;
    logic [Y_W-1:0]            w_y;
    logic [KP_W-1:0]           w_kp;

    // Let each stage load when empty or when it drains
    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = w_rdy2;

    // Quotient estimate, then remainder below twice the period
    assign w_quot = r_s2_prod[2*NOW_W-1:NOW_W];
    assign w_diff = r_s2_now - NOW_W'(w_quot * PERIOD_MS);

    // Correct the remainder and scale it to a table index
    assign w_rem = (r_s3_rem0 >= REM0_W'(PERIOD_MS)) ?
                   REM_W'(r_s3_rem0 - REM0_W'(PERIOD_MS)) : REM_W'(r_s3_rem0);
    assign w_y   = Y_W'(w_rem) * Y_W'(SINE_ENTRIES);
    assign w_kp  = KP_W'(w_y) * KP_W'(K_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_v2 <= i_valid;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && i_valid) begin
            r_s2_now    <= i_req.now;
            r_s2_prod   <= (2*NOW_W)'(i_req.now) * (2*NOW_W)'(DIV_MUL);
            r_s2_saving <= i_req.saving;
        end
        if (w_rdy3 && r_v2) begin
            r_s3_rem0   <= REM0_W'(w_diff);
            r_s3_saving <= r_s2_saving;
        end
        if (w_rdy4 && r_v3) begin
            r_s4_req.k      <= K_W'(w_kp >> K_SHIFT);
            r_s4_req.saving <= r_s3_saving;
        end
    end

    assign o_valid = r_v4;
    assign o_req   = r_s4_req;

`ifndef SYNTHESIS
    a_rem0_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (32'(r_s3_rem0) < 2 * PERIOD_MS))
        else $error("remainder estimate out of range");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (32'(r_s4_req.k) < SINE_ENTRIES))
        else $error("table index out of range");
`endif

endmodule

FILE: hw/rtl/blcd_scale.sv
// Scaling stages: level lookup, colour expansion and channel scaling.
`timescale 1ns / 1ps

module blcd_scale
    import blcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COLOR_W-1:0] i_base_color,
    input  logic               i_valid,
    input  t_level_req         i_req,
    output logic               o_ready,
    blcd_out_if.source         o_out
);

    localparam int P_W = CH_W + LEVEL_W;

    logic               r_v5;
    logic               r_v6;
    logic               w_rdy5;
    logic               w_rdy6;
    logic [LEVEL_W-1:0] r_level;
    logic               r_saving;
    logic [CH_W-1:0]    r_red;
    logic [CH_W-1:0]    r_green;
    logic [CH_W-1:0]    r_blue;
    logic [CH_W-1:0]    w_red8;
    logic [CH_W-1:0]    w_green8;
    logic [CH_W-1:0]    w_blue8;
    logic [P_W-1:0]     w_red_p;
    logic [P_W-1:0]     w_green_p;
    logic [P_W-1:0]     w_blue_p;

    assign w_rdy6  = !r_v6 || o_out.ready;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign o_ready = w_rdy5;

    // Expand RGB565 to 8 bits per channel
    assign w_red8   = EXP5_LUT[i_base_color[15:11]];
    assign w_green8 = EXP6_LUT[i_base_color[10:5]];
    assign w_blue8  = EXP5_LUT[i_base_color[4:0]];

    // Scale each channel by the Q0.16 level
    assign w_red_p   = P_W'(w_red8)   * P_W'(r_level);
    assign w_green_p = P_W'(w_green8) * P_W'(r_level);
    assign w_blue_p  = P_W'(w_blue8)  * P_W'(r_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy5) begin
                r_v5 <= i_valid;
            end
            if (w_rdy6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && i_valid) begin
            r_level  <= SINE_LUT[i_req.k];
            r_saving <= i_req.saving;
        end
        // Drop to black while power saving
        if (w_rdy6 && r_v5) begin
            r_red   <= r_saving ? '0 : w_red_p[P_W-1:LEVEL_W];
            r_green <= r_saving ? '0 : w_green_p[P_W-1:LEVEL_W];
            r_blue  <= r_saving ? '0 : w_blue_p[P_W-1:LEVEL_W];
        end
    end

    assign o_out.valid = r_v6;
    assign o_out.red   = r_red;
    assign o_out.green = r_green;
    assign o_out.blue  = r_blue;

endmodule

FILE: hw/rtl/breathing_led_color_driver.sv
// Top level of the breathing LED colour driver: configuration registers and pipeline.
`timescale 1ns / 1ps

// Each accepted time sample is checked against the 45 ms update interval in the
// cycle it is taken; samples that do not update the LED give no result, while
// an update travels a six-register pipeline (interval gate, period reciprocal
// multiply, remainder, table index, level lookup, channel scaling) and is valid
// on the output channel once it leaves the channel scaling register. One request
// is taken every cycle while the output is drained; the input stalls only once
// every stage holds a waiting result. Write base_color and enabled only while
// idle.

module breathing_led_color_driver
    import blcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    blcd_in_if.sink              i_in,
    blcd_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    logic [COLOR_W-1:0] r_base_color;
    logic               r_enabled;
    logic               w_gate_valid;
    logic               w_gate_ready;
    t_time_req          w_gate_req;
    logic               w_phase_valid;
    logic               w_phase_ready;
    t_level_req         w_phase_req;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_color <= '0;
            r_enabled    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_BASE_COLOR: r_base_color <= i_cfg_data;
                CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    blcd_gate u_gate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_enabled (r_enabled),
        .i_in      (i_in),
        .o_valid   (w_gate_valid),
        .o_req     (w_gate_req),
        .i_ready   (w_gate_ready)
    );

    blcd_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_gate_valid),
        .i_req   (w_gate_req),
        .o_ready (w_gate_ready),
        .o_valid (w_phase_valid),
        .o_req   (w_phase_req),
        .i_ready (w_phase_ready)
    );

    blcd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_base_color (r_base_color),
        .i_valid      (w_phase_valid),
        .i_req        (w_phase_req),
        .o_ready      (w_phase_ready),
        .o_out        (o_out)
    );

endmodule
